// ===== src/phvc_pkg.sv =====
// package for the pairwise hyperplane vote classifier
// constants, opcodes, state encoding; no dependencies
package phvc_pkg;

   localparam int MaxOptimaDefault  = 8;
   localparam int MaxDimsDefault    = 4;
   localparam int CountWidthDefault = 16;

   typedef enum logic [1:0] {
      OP_LOAD_COEF  = 2'd0,
      OP_LOAD_THR   = 2'd1,
      OP_CLASSIFY   = 2'd2,
      OP_CLOSE      = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_MAC,
      ST_CMP,
      ST_ARGMAX,
      ST_WINNER,
      ST_HIST_RD,
      ST_HIST,
      ST_CLEAR
   } state_type;

   localparam logic [0:0] REG_NUM_DIMS = 1'b0;
   localparam logic [0:0] REG_OPTIMA   = 1'b1;

endpackage

// ===== src/phvc_csr.sv =====
// configuration registers of the classifier on an apb-style port
// depends on phvc_pkg
module phvc_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [2:0]  num_dims,
   output logic [4:0]  optima_limit
);
   import phvc_pkg::*;

   logic [2:0] dims_ff;
   logic [4:0] optima_ff;
   logic       wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff   <= 3'd4;
         optima_ff <= 5'd8;
      end else if (wr && csr_paddr[1:0] == 2'b00) begin
         if (csr_paddr[2] == REG_NUM_DIMS) dims_ff <= csr_pwdata[2:0];
         else optima_ff <= csr_pwdata[4:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_NUM_DIMS) csr_prdata = {29'd0, dims_ff};
      else csr_prdata = {27'd0, optima_ff};
   end

   assign num_dims     = dims_ff;
   assign optima_limit = optima_ff;
endmodule

// ===== src/phvc_mac.sv =====
// dot product lane: multiplies coords by coefficients and sums exactly
// no package dependency; one product per lane, registered, then summed
module phvc_mac #(
   parameter int MAX_DIMS = 4
) (
   input  logic               clock,
   input  logic [MAX_DIMS*32-1:0] coords,
   input  logic [MAX_DIMS*32-1:0] coefs,
   input  logic [MAX_DIMS-1:0]    lane_en,
   output logic signed [65:0]     dot
);
   logic signed [63:0] prod_ff [MAX_DIMS];
   logic signed [65:0] sum;

   always_ff @(posedge clock) begin
      for (int t = 0; t < MAX_DIMS; t++) begin
         prod_ff[t] <= lane_en[t] ? ($signed(coords[t*32 +: 32]) * $signed(coefs[t*32 +: 32]))
                                  : 64'sd0;
      end
   end

   always_comb begin
      sum = '0;
      for (int t = 0; t < MAX_DIMS; t++) sum = sum + 66'(prod_ff[t]);
   end
   assign dot = sum;
endmodule

// ===== src/pairwise_hyperplane_vote_classifier.sv =====
// top level of the pairwise hyperplane vote classifier
// depends on phvc_pkg, phvc_csr, phvc_mac
//
// channel | dir | handshake        | contents
// req     | in  | tvalid/tready    | opcode, pair, dim, value, dir, unassigned, coords
// rsp     | out | tvalid/tready    | is_histogram, winner, index, count, total, last
// csr     | in  | apb, pready high | num_dims, optima count
//
// a load is taken in its accept cycle; a sample is accepted, clears every vote entry,
// steps each pair through issue, multiply, compare and vote write-back, then scans the votes
// for the argmax; an unassigned sample skips the vote; closing sends each histogram word.
// a word waiting on rsp_tready holds the winner or histogram step until it leaves.
// reset clears counts in flip-flops at once; tables are undefined until loaded.
// one item is in work at a time; req_tready is low while an item is in flight.
module pairwise_hyperplane_vote_classifier #(
   parameter int MAX_OPTIMA  = phvc_pkg::MaxOptimaDefault,
   parameter int MAX_DIMS    = phvc_pkg::MaxDimsDefault,
   parameter int COUNT_WIDTH = phvc_pkg::CountWidthDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[1:0] pair_low[5:2] pair_high[9:6] dim_index[11:10] table_value[43:12]
   // direction[44] sample_unassigned[45] coord0[77:46] coord1[109:78]
   // coord2[141:110] coord3[173:142], zero fill to 176
   input  logic [175:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // winner[3:0] optimum_index[7:4] optimum_count[23:8] samples_total[39:24]
   output logic [39:0]  rsp_tdata,
   // is_histogram
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import phvc_pkg::*;

   localparam int OW  = $clog2(MAX_OPTIMA);
   localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int PW  = 2 * OW;
   localparam int VW  = $clog2(MAX_OPTIMA + 1);
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

   logic [2:0] num_dims;
   logic [4:0] optima_limit;

   phvc_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .num_dims, .optima_limit
   );

   // effective configuration
   logic [OW:0] no_eff;
   logic [2:0]  nd_eff;
   always_comb begin
      if (optima_limit < 5'd2) no_eff = (OW+1)'(2);
      else if (optima_limit > 5'(MAX_OPTIMA)) no_eff = (OW+1)'(MAX_OPTIMA);
      else no_eff = optima_limit[OW:0];
      if (num_dims < 3'd1) nd_eff = 3'd1;
      else if (num_dims > 3'(MAX_DIMS)) nd_eff = 3'(MAX_DIMS);
      else nd_eff = num_dims;
   end

   // input fields
   logic [1:0]  f_op;
   logic [3:0]  f_pl, f_ph;
   logic [1:0]  f_di;
   logic [31:0] f_val;
   logic        f_dir, f_un;
   assign f_op  = req_tdata[1:0];
   assign f_pl  = req_tdata[5:2];
   assign f_ph  = req_tdata[9:6];
   assign f_di  = req_tdata[11:10];
   assign f_val = req_tdata[43:12];
   assign f_dir = req_tdata[44];
   assign f_un  = req_tdata[45];

   // memories
   logic [MAX_DIMS*32-1:0] coef_mem [1 << PW];
   logic [32:0]            thr_mem  [1 << PW];
   logic [MAX_DIMS*32-1:0] coef_rd_ff;
   logic [32:0]            thr_rd_ff;
   logic [MAX_DIMS-1:0]    coef_lane_we;
   logic                   coef_we, thr_we;
   logic [PW-1:0]          ld_addr, rd_addr;

   always_ff @(posedge clock) begin
      if (coef_we) begin
         for (int t = 0; t < MAX_DIMS; t++)
            if (coef_lane_we[t]) coef_mem[ld_addr][t*32 +: 32] <= f_val;
      end
      if (thr_we) thr_mem[ld_addr] <= {f_dir, f_val};
      coef_rd_ff <= coef_mem[rd_addr];
      thr_rd_ff  <= thr_mem[rd_addr];
   end

   // vote memory (read-modify-write), counts in registers
   logic [VW-1:0] vote_mem [MAX_OPTIMA];
   logic [VW-1:0] vote_rd_ff;
   logic          vote_we;
   logic [OW-1:0] vote_waddr, vote_raddr;
   logic [VW-1:0] vote_wdata;
   always_ff @(posedge clock) begin
      if (vote_we) vote_mem[vote_waddr] <= vote_wdata;
      vote_rd_ff <= vote_mem[vote_raddr];
   end

   logic [COUNT_WIDTH-1:0] pref_ff [MAX_OPTIMA];
   logic [COUNT_WIDTH-1:0] seen_ff;

   state_type state_ff, state_in;
   logic [1:0]  op_ff;
   logic        un_ff;
   logic [MAX_DIMS*32-1:0] pos_ff;
   logic [OW-1:0] i_ff, i_in, j_ff, j_in;
   logic [OW-1:0] best_ff, best_in;
   logic [VW-1:0] bestv_ff, bestv_in;
   logic          clr_ff, clr_in;

   // output register
   logic        o_valid_ff;
   logic [39:0] o_data_ff;
   logic        o_user_ff, o_last_ff;
   logic        o_load;
   logic [39:0] o_data_in;
   logic        o_user_in, o_last_in;

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = o_data_ff;
   assign rsp_tuser  = o_user_ff;
   assign rsp_tlast  = o_last_ff;

   logic out_free;
   assign out_free = !o_valid_ff || rsp_tready;

   logic [MAX_DIMS-1:0] lane_en;
   always_comb begin
      for (int t = 0; t < MAX_DIMS; t++) lane_en[t] = 3'(t) < nd_eff;
   end

   logic signed [65:0] dot;
   phvc_mac #(.MAX_DIMS(MAX_DIMS)) u_mac (
      .clock, .coords(pos_ff), .coefs(coef_rd_ff), .lane_en, .dot
   );

   // threshold is q16.16, the dot product q32.32
   logic signed [65:0] thr_ext;
   logic               below, to_i;
   assign thr_ext = {{18{thr_rd_ff[31]}}, thr_rd_ff[31:0], 16'd0};
   assign below   = dot <= thr_ext;
   assign to_i    = below ? thr_rd_ff[32] : !thr_rd_ff[32];

   logic [15:0] seen16;
   assign seen16 = (COUNT_WIDTH > 16 && seen_ff > COUNT_WIDTH'(16'hFFFF)) ? 16'hFFFF
                   : 16'(seen_ff);

   logic [15:0] pref16;
   assign pref16 = (COUNT_WIDTH > 16 && pref_ff[i_ff] > COUNT_WIDTH'(16'hFFFF)) ? 16'hFFFF
                   : 16'(pref_ff[i_ff]);

   logic req_ok;
   assign req_ok = req_tvalid && req_tready;
   assign req_tready = state_ff == ST_IDLE;

   logic ld_ok;
   assign ld_ok = ({1'b0, f_pl} < 5'(MAX_OPTIMA)) && ({1'b0, f_ph} < 5'(MAX_OPTIMA));
   assign ld_addr = {f_pl[OW-1:0], f_ph[OW-1:0]};

   logic last_pair;
   assign last_pair = ((OW+1)'(j_ff) + 1'b1 == no_eff) &&
                      ((OW+1)'(i_ff) + 2'd2 == no_eff);

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      best_in    = best_ff;
      bestv_in   = bestv_ff;
      clr_in     = clr_ff;
      coef_we    = 1'b0;
      thr_we     = 1'b0;
      coef_lane_we = '0;
      rd_addr    = {i_ff, j_ff};
      vote_we    = 1'b0;
      vote_waddr = i_ff;
      vote_raddr = i_ff;
      vote_wdata = '0;
      o_load     = 1'b0;
      o_data_in  = '0;
      o_user_in  = 1'b0;
      o_last_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_ok) begin
               case (opcode_type'(f_op))
                  OP_LOAD_COEF: begin
                     coef_we = ld_ok && (32'(f_di) < MAX_DIMS);
                     for (int t = 0; t < MAX_DIMS; t++) coef_lane_we[t] = f_di == 2'(t);
                  end
                  OP_LOAD_THR: thr_we = ld_ok;
                  default: begin
                     i_in   = '0;
                     clr_in = 1'b1;
                     state_in = f_un ? (f_op == OP_CLOSE ? ST_HIST_RD : ST_IDLE) : ST_CLEAR;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            // zero the vote memory one entry a cycle
            vote_we = 1'b1;
            vote_wdata = '0;
            if (i_ff == OW'(MAX_OPTIMA - 1)) begin
               i_in = '0;
               j_in = OW'(1);
               state_in = ST_ISSUE;
            end else i_in = i_ff + 1'b1;
         end
         ST_ISSUE: begin
            // memory read of coef/threshold
            state_in = ST_MAC;
         end
         ST_MAC: begin
            // products registered; read vote of chosen side next
            state_in = ST_CMP;
         end
         ST_CMP: begin
            vote_raddr = to_i ? i_ff : j_ff;
            state_in = ST_ARGMAX; // used as vote write-back step
            clr_in = to_i;
         end
         ST_ARGMAX: begin
            if (clr_ff) begin
               vote_waddr = i_ff;
            end else begin
               vote_waddr = j_ff;
            end
            vote_we = 1'b1;
            vote_wdata = vote_rd_ff + 1'b1;
            if (last_pair) begin
               i_in = '0;
               j_in = '0;
               best_in = '0;
               bestv_in = '0;
               state_in = ST_WINNER;
               vote_raddr = '0;
            end else begin
               if ((OW+1)'(j_ff) + 1'b1 == no_eff) begin
                  i_in = i_ff + 1'b1;
                  j_in = i_ff + OW'(2);
               end else j_in = j_ff + 1'b1;
               state_in = ST_ISSUE;
            end
         end
         ST_WINNER: begin
            // argmax scan: vote_rd_ff holds entry i_ff; j_ff set while the word waits
            if (j_ff == '0) begin
               vote_raddr = i_ff + 1'b1;
               if (i_ff == '0 || vote_rd_ff > bestv_ff) begin
                  best_in  = i_ff;
                  bestv_in = vote_rd_ff;
               end
               if ((OW+1)'(i_ff) + 1'b1 == no_eff) begin
                  if (out_free) begin
                     o_load    = 1'b1;
                     o_last_in = op_ff == OP_CLASSIFY;
                     o_data_in = {seen16, 16'd0, 4'd0, 4'(best_in)};
                     state_in  = op_ff == OP_CLOSE ? ST_HIST_RD : ST_IDLE;
                     i_in = '0;
                     j_in = '0;
                  end else j_in = OW'(1);
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else if (out_free) begin
               o_load    = 1'b1;
               o_last_in = op_ff == OP_CLASSIFY;
               o_data_in = {seen16, 16'd0, 4'd0, 4'(best_ff)};
               state_in  = op_ff == OP_CLOSE ? ST_HIST_RD : ST_IDLE;
               i_in = '0;
               j_in = '0;
            end
         end
         ST_HIST_RD: begin
            state_in = ST_HIST;
         end
         ST_HIST: begin
            if (out_free) begin
               o_load    = 1'b1;
               o_user_in = 1'b1;
               o_last_in = (OW+1)'(i_ff) + 1'b1 == no_eff;
               o_data_in = {seen16, pref16, 4'(i_ff), 4'd0};
               if (o_last_in) state_in = ST_IDLE;
               else begin
                  i_in = i_ff + 1'b1;
                  state_in = ST_HIST_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // winner entry updates the preference count
   logic win_fire, close_done;
   logic [OW-1:0] win_idx;
   assign win_fire   = state_ff == ST_WINNER && o_load;
   assign win_idx    = o_data_in[OW-1:0];
   assign close_done = state_ff == ST_HIST && o_load && o_last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         o_valid_ff <= 1'b0;
         seen_ff    <= '0;
         for (int k = 0; k < MAX_OPTIMA; k++) pref_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         if (o_load) o_valid_ff <= 1'b1;
         else if (rsp_tready) o_valid_ff <= 1'b0;
         if (req_ok && f_op[1] && seen_ff != CMAX) seen_ff <= seen_ff + 1'b1;
         if (win_fire && pref_ff[win_idx] != CMAX)
            pref_ff[win_idx] <= pref_ff[win_idx] + 1'b1;
         if (close_done) begin
            seen_ff <= '0;
            for (int k = 0; k < MAX_OPTIMA; k++) pref_ff[k] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      j_ff     <= j_in;
      best_ff  <= best_in;
      bestv_ff <= bestv_in;
      clr_ff   <= clr_in;
      if (req_ok) begin
         op_ff  <= f_op;
         un_ff  <= f_un;
         pos_ff <= req_tdata[46 +: MAX_DIMS*32];
      end
      if (o_load) begin
         o_data_ff <= o_data_in;
         o_user_ff <= o_user_in;
         o_last_ff <= o_last_in;
      end
   end

`ifndef ASSERT_OFF
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_tready) else $error("input taken while busy");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped under stall");
   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      close_done |=> seen_ff == '0) else $error("sample count not cleared");
   a_unassigned_no_win: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WINNER |-> !un_ff) else $error("unassigned sample voted");
`endif
endmodule

// ===== verif/phvc_checker.sv =====
// result checker for the pairwise hyperplane vote classifier
// watches the req, rsp and csr channels, predicts words; depends on phvc_pkg
`timescale 1ns / 1ps
module phvc_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [175:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [39:0]  rsp_tdata,
   input  logic         rsp_tuser,
   input  logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output int           fail_count,
   output int           pending
);
   import phvc_pkg::*;

   localparam int NOPT = MaxOptimaDefault;
   localparam int NDIM = MaxDimsDefault;

   typedef struct packed {
      logic        hist;
      logic [3:0]  winner;
      logic [3:0]  index;
      logic [15:0] count;
      logic [15:0] total;
      logic        last;
   } word_type;

   logic signed [31:0] coef_tab [NOPT*NOPT*NDIM];
   logic signed [31:0] thr_tab [NOPT*NOPT];
   logic               dir_tab [NOPT*NOPT];
   logic [15:0]        win_counts [NOPT];
   logic [15:0]        seen;
   logic [2:0]         dims_reg;
   logic [4:0]         optima_reg;
   word_type           expected_words [$];

   function automatic logic below_plane(logic [175:0] d, int i, int j, int nd);
      logic signed [95:0] acc;
      logic signed [95:0] thr;
      logic signed [31:0] c;
      acc = 0;
      for (int t = 0; t < nd; t++) begin
         c = d[46 + 32*t +: 32];
         acc += 96'(c) * 96'(coef_tab[(i*NOPT + j)*NDIM + t]);
      end
      thr = 96'(thr_tab[i*NOPT + j]) <<< 16;
      return acc <= thr;
   endfunction

   task automatic predict_item(logic [175:0] d);
      opcode_type op;
      int pl, ph, di, no, nd, best;
      int votes [NOPT];
      logic to_i;
      word_type w;
      op = opcode_type'(d[1:0]);
      pl = d[5:2];
      ph = d[9:6];
      di = d[11:10];
      if (op == OP_LOAD_COEF) begin
         if (pl < NOPT && ph < NOPT && di < NDIM)
            coef_tab[(pl*NOPT + ph)*NDIM + di] = d[43:12];
         return;
      end
      if (op == OP_LOAD_THR) begin
         if (pl < NOPT && ph < NOPT) begin
            thr_tab[pl*NOPT + ph] = d[43:12];
            dir_tab[pl*NOPT + ph] = d[44];
         end
         return;
      end
      no = optima_reg < 2 ? 2 : (optima_reg > NOPT ? NOPT : optima_reg);
      nd = dims_reg < 1 ? 1 : (dims_reg > NDIM ? NDIM : dims_reg);
      if (seen != 16'hffff) seen++;
      if (!d[45]) begin
         for (int i = 0; i < NOPT; i++) votes[i] = 0;
         for (int i = 0; i + 1 < no; i++)
            for (int j = i + 1; j < no; j++) begin
               to_i = below_plane(d, i, j, nd) ? dir_tab[i*NOPT + j] : !dir_tab[i*NOPT + j];
               if (to_i) votes[i]++;
               else votes[j]++;
            end
         best = 0;
         for (int i = 1; i < no; i++) if (votes[i] > votes[best]) best = i;
         if (win_counts[best] != 16'hffff) win_counts[best]++;
         w = '{1'b0, 4'(best), 4'd0, 16'd0, seen, op == OP_CLASSIFY};
         expected_words.insert(expected_words.size(), w);
      end
      if (op == OP_CLOSE) begin
         for (int i = 0; i < no; i++) begin
            w = '{1'b1, 4'd0, 4'(i), win_counts[i], seen, i + 1 == no};
            expected_words.insert(expected_words.size(), w);
         end
         for (int i = 0; i < NOPT; i++) win_counts[i] = 0;
         seen = 0;
      end
   endtask

   always @(posedge clock) begin
      word_type got, exp_w;
      if (reset) begin
         fail_count <= 0;
         pending <= 0;
         seen = 0;
         dims_reg = 3'd4;
         optima_reg = 5'd8;
         for (int i = 0; i < NOPT; i++) win_counts[i] = 0;
         expected_words.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr[2] == REG_OPTIMA) optima_reg = csr_pwdata[4:0];
            else dims_reg = csr_pwdata[2:0];
         end
         if (req_tvalid && req_tready) predict_item(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser, rsp_tdata[3:0], rsp_tdata[7:4], rsp_tdata[23:8],
                    rsp_tdata[39:24], rsp_tlast};
            if (expected_words.size() == 0) begin
               if (fail_count < 10) $display("unexpected result word %h", got);
               fail_count <= fail_count + 1;
            end else begin
               exp_w = expected_words.pop_front();
               if (got !== exp_w) begin
                  if (fail_count < 10)
                     $display({"mismatch: expected hist=%b win=%0d idx=%0d cnt=%0d ",
                               "tot=%0d last=%b, got hist=%b win=%0d idx=%0d cnt=%0d ",
                               "tot=%0d last=%b"},
                        exp_w.hist, exp_w.winner, exp_w.index, exp_w.count, exp_w.total,
                        exp_w.last, got.hist, got.winner, got.index, got.count, got.total,
                        got.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= expected_words.size();
      end
   end
endmodule

// ===== verif/tb_top.sv =====
// stimulus and verdict for the pairwise hyperplane vote classifier
// drives req and csr, stalls rsp; depends on phvc_pkg and phvc_checker
`timescale 1ns / 1ps
module tb_top;
   import phvc_pkg::*;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [175:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [39:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_psel = 0;
   logic         csr_penable = 0;
   logic         csr_pwrite = 0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;
   int           fail_count;
   int           pending;
   int           hold_off = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   pairwise_hyperplane_vote_classifier DUT (.*);

   phvc_checker checker_i (.*);

   // receiver: random stalls, plus a long hold-off when asked
   initial begin
      int wait_n;
      @(negedge clock);
      forever begin
         if (hold_off > 0) begin
            wait_n = hold_off;
            hold_off = 0;
         end else
            wait_n = $urandom_range(0, 5) * ($urandom_range(0, 3) != 0);
         if (wait_n > 0) begin
            rsp_tready <= 0;
            repeat (wait_n) @(negedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic csr_write(logic [0:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   // valid stays up after the accepting edge until the next word or drain
   task automatic send_word(logic [175:0] d, bit gaps);
      int n;
      n = gaps ? $urandom_range(0, 5) : 0;
      @(negedge clock);
      if (n > 0) begin
         req_tvalid <= 0;
         repeat (n) @(negedge clock);
      end
      req_tdata <= d;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [175:0] make_word(opcode_type op, int pl, int ph, int di,
                                              logic [31:0] val, logic dir, logic unas,
                                              logic [127:0] coords);
      return {2'b00, coords, unas, dir, val, 2'(di), 4'(ph), 4'(pl), 2'(op)};
   endfunction

   function automatic logic [31:0] rnd_val();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [127:0] rnd_coords();
      return {rnd_val(), rnd_val(), rnd_val(), rnd_val()};
   endfunction

   // fill every coefficient, threshold and direction of the pairs i < j, so no unwritten entry is read
   task automatic load_table(bit gaps);
      for (int i = 0; i < 8; i++)
         for (int j = i + 1; j < 8; j++) begin
            for (int t = 0; t < 4; t++)
               send_word(make_word(OP_LOAD_COEF, i, j, t, rnd_val(), 0, 0, '0), gaps);
            send_word(make_word(OP_LOAD_THR, i, j, 0, rnd_val(), $urandom_range(0, 1),
                                0, '0), gaps);
         end
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic sample_burst(int n, bit gaps);
      opcode_type op;
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(0, 9))
            0: op = OP_LOAD_COEF;
            1: op = OP_LOAD_THR;
            2, 3: op = OP_CLOSE;
            default: op = OP_CLASSIFY;
         endcase
         // loads may hit out-of-range or unused pairs; used pairs stay loaded
         send_word(make_word(op, $urandom_range(0, 15), $urandom_range(0, 15),
                             $urandom_range(0, 3), rnd_val(), $urandom_range(0, 1),
                             $urandom_range(0, 4) == 0, rnd_coords()), gaps);
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      load_table(0);
      // directed: extremes, unassigned, close at reset config
      send_word(make_word(OP_CLASSIFY, 0, 0, 0, '0, 0, 0, {4{32'h8000_0000}}), 0);
      send_word(make_word(OP_CLASSIFY, 0, 0, 0, '0, 0, 0, {4{32'h7fff_ffff}}), 0);
      send_word(make_word(OP_CLASSIFY, 0, 0, 0, '0, 0, 0, '0), 0);
      send_word(make_word(OP_CLASSIFY, 0, 0, 0, '0, 0, 1, rnd_coords()), 0);
      send_word(make_word(OP_LOAD_COEF, 15, 15, 3, 32'hffff_ffff, 1, 1, '1), 0);
      send_word(make_word(OP_LOAD_THR, 9, 2, 0, 32'hffff_ffff, 1, 0, '0), 0);
      send_word(make_word(OP_CLOSE, 0, 0, 0, '0, 0, 1, rnd_coords()), 0);
      send_word(make_word(OP_CLOSE, 0, 0, 0, '0, 0, 0, rnd_coords()), 0);
      send_word(make_word(OP_CLOSE, 0, 0, 0, '0, 0, 0, rnd_coords()), 0);
      drain();
      // register sweep including out-of-range values that clamp
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin csr_write(REG_NUM_DIMS, 1); csr_write(REG_OPTIMA, 2); end
            1: begin csr_write(REG_NUM_DIMS, 0); csr_write(REG_OPTIMA, 31); end
            2: begin csr_write(REG_NUM_DIMS, 7); csr_write(REG_OPTIMA, 0); end
            3: begin csr_write(REG_NUM_DIMS, 2); csr_write(REG_OPTIMA, 5); end
            4: begin csr_write(REG_NUM_DIMS, 3); csr_write(REG_OPTIMA, 16); end
            default: begin csr_write(REG_NUM_DIMS, 4); csr_write(REG_OPTIMA, 8); end
         endcase
         if (ph == 3) begin
            hold_off = 400;
            sample_burst(12, 0);
         end else
            sample_burst(20, 1);
         if (ph == 5) load_table(1);
         drain();
      end
      sample_burst(30, 1);
      drain();
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end
endmodule

// ===== sim.f =====
src/phvc_pkg.sv
src/phvc_csr.sv
src/phvc_mac.sv
src/pairwise_hyperplane_vote_classifier.sv
verif/phvc_checker.sv
verif/tb_top.sv
